### src/frq_pkg.sv
// Shared constants, codes and control types for the FIFO ready queue.
package frq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 8;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Command codes
  localparam logic [1:0] CMD_ADD       = 2'd0;
  localparam logic [1:0] CMD_YIELD     = 2'd1;
  localparam logic [1:0] CMD_TERMINATE = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic start;      // arm a search: token into cell 0, mark all cells pending
    logic advance;    // token moves one cell up the chain
    logic clear;      // drop the token
    logic shift_hit;  // pending cells take their upper neighbor's id
    logic shift_all;  // every cell takes its upper neighbor's id (pop head)
  } cell_ctrl_t;

endpackage

### src/frq_cell.sv
// One queue slot: holds an id, a search token and a pending flag.
module frq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  frq_pkg::cell_ctrl_t          ctrl_i,
  input  logic                         wr_en_i,
  input  logic [frq_pkg::ID_WIDTH-1:0] wr_data_i,
  input  logic [frq_pkg::ID_WIDTH-1:0] key_i,
  input  logic [frq_pkg::ID_WIDTH-1:0] next_id_i,
  input  logic                         tok_i,
  output logic [frq_pkg::ID_WIDTH-1:0] id_o,
  output logic                         tok_o,
  output logic                         hit_o
);

  logic [frq_pkg::ID_WIDTH-1:0] id_q, id_d;
  logic                         tok_q, tok_d;
  logic                         pend_q, pend_d;

  // Slot data: load at tail, shift down on removal
  always_comb begin
    id_d = id_q;
    if (wr_en_i) begin
      id_d = wr_data_i;
    end else if (ctrl_i.shift_all || (ctrl_i.shift_hit && pend_q)) begin
      id_d = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  // Token walks one cell per cycle while advance is set; a cell it passed is no longer pending
  always_comb begin
    tok_d  = tok_q;
    pend_d = pend_q;
    if (ctrl_i.clear) begin
      tok_d = 1'b0;
    end else if (ctrl_i.advance) begin
      tok_d = tok_i;
    end
    if (ctrl_i.start) begin
      pend_d = 1'b1;
    end else if (ctrl_i.advance && tok_q) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      pend_q <= pend_d;
    end
  end

  assign id_o  = id_q;
  assign tok_o = tok_q;
  assign hit_o = tok_q && (id_q == key_i);

endmodule

### src/frq_ctrl.sv
// Command sequencer: entry count, search walk and the result register.
module frq_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  output logic                            s_ready_o,
  input  logic [1:0]                      cmd_i,
  input  logic [7:0]                      tid_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [1:0]                      status_o,
  output logic [7:0]                      disp_o,
  output logic [4:0]                      count_o,
  output frq_pkg::cell_ctrl_t             ctrl_o,
  output logic [frq_pkg::QUEUE_DEPTH-1:0] wr_en_o,
  output logic [frq_pkg::ID_WIDTH-1:0]    wr_data_o,
  output logic [frq_pkg::ID_WIDTH-1:0]    key_o,
  input  logic [frq_pkg::ID_WIDTH-1:0]    head_id_i,
  input  logic [frq_pkg::QUEUE_DEPTH-1:0] hit_i
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic                          state_q, state_d;
  logic [frq_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [frq_pkg::IDX_W-1:0]     pos_q, pos_d;
  logic [frq_pkg::ID_WIDTH-1:0]  key_q, key_d;
  logic                          mv_q, mv_d;
  logic [1:0]                    stat_q, stat_d;
  logic [7:0]                    disp_q, disp_d;
  logic [4:0]                    rcnt_q, rcnt_d;

  logic                          out_free;
  logic                          accept;
  logic                          any_hit;
  logic                          last_pos;
  logic                          load_out;
  logic [frq_pkg::ID_WIDTH-1:0]  in_id;

  assign out_free  = !mv_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE) && out_free;
  assign accept    = s_valid_i && s_ready_o;
  assign any_hit   = |hit_i;
  assign last_pos  = ((frq_pkg::CNT_W'(pos_q) + frq_pkg::CNT_W'(1)) == cnt_q);
  assign in_id     = frq_pkg::ID_WIDTH'(tid_i);
  assign wr_data_o = in_id;
  assign key_o     = key_q;

  // Tail write enable, one per cell
  always_comb begin
    for (int i = 0; i < frq_pkg::QUEUE_DEPTH; i++) begin
      wr_en_o[i] = accept && (cmd_i == frq_pkg::CMD_ADD) &&
                   (cnt_q == frq_pkg::CNT_W'(i));
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    key_d    = key_q;
    ctrl_o   = '0;
    load_out = 1'b0;
    stat_d   = stat_q;
    disp_d   = disp_q;
    rcnt_d   = rcnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          stat_d = frq_pkg::STAT_OK;
          disp_d = '0;
          case (cmd_i)
            frq_pkg::CMD_ADD: begin
              load_out = 1'b1;
              if (cnt_q == frq_pkg::CNT_W'(frq_pkg::QUEUE_DEPTH)) begin
                stat_d = frq_pkg::STAT_FULL;
              end else begin
                cnt_d = cnt_q + frq_pkg::CNT_W'(1);
              end
            end
            frq_pkg::CMD_YIELD: begin
              load_out = 1'b1;
              if (cnt_q == '0) begin
                stat_d = frq_pkg::STAT_EMPTY;
              end else begin
                disp_d           = 8'(head_id_i);
                ctrl_o.shift_all = 1'b1;
                cnt_d            = cnt_q - frq_pkg::CNT_W'(1);
              end
            end
            frq_pkg::CMD_TERMINATE: begin
              if (cnt_q == '0) begin
                load_out = 1'b1;
                stat_d   = frq_pkg::STAT_NOT_FOUND;
              end else begin
                key_d          = in_id;
                pos_d          = '0;
                ctrl_o.start   = 1'b1;
                ctrl_o.advance = 1'b1;
                state_d        = S_SEARCH;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
          rcnt_d = 5'(cnt_d);
        end
      end
      S_SEARCH: begin
        // Token sits at cell pos_q; finish only when the result slot is free
        if (any_hit) begin
          if (out_free) begin
            ctrl_o.shift_hit = 1'b1;
            ctrl_o.clear     = 1'b1;
            cnt_d            = cnt_q - frq_pkg::CNT_W'(1);
            load_out         = 1'b1;
            stat_d           = frq_pkg::STAT_OK;
            disp_d           = '0;
            rcnt_d           = 5'(cnt_d);
            state_d          = S_IDLE;
          end
        end else if (last_pos) begin
          if (out_free) begin
            ctrl_o.clear = 1'b1;
            load_out     = 1'b1;
            stat_d       = frq_pkg::STAT_NOT_FOUND;
            disp_d       = '0;
            rcnt_d       = 5'(cnt_q);
            state_d      = S_IDLE;
          end
        end else begin
          ctrl_o.advance = 1'b1;
          pos_d          = pos_q + frq_pkg::IDX_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    mv_d = mv_q;
    if (load_out) begin
      mv_d = 1'b1;
    end else if (m_ready_i) begin
      mv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pos_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      mv_q    <= mv_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (load_out) begin
      stat_q <= stat_d;
      disp_q <= disp_d;
      rcnt_q <= rcnt_d;
    end
  end

  assign m_valid_o = mv_q;
  assign status_o  = stat_q;
  assign disp_o    = disp_q;
  assign count_o   = rcnt_q;

endmodule

### src/fifo_ready_queue_with_removal.sv
// Top level of the FIFO ready queue: sequencer plus a chain of slot cells.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-------------------------------------
//  command  | in  | s_axis_tvalid / s_axis_tready | tdata: thread_id; tuser: cmd
//  result   | out | m_axis_tvalid / m_axis_tready | tdata: dispatched_id, queue_count;
//           |     |                              | tuser: status
//
// Add, yield and unused codes finish in the cycle they are accepted.
// Terminate walks a token up the cell chain, one cell per cycle, until it
// reaches the match or the last entry; on an empty queue it finishes when
// accepted. The removal shift happens once the match is found and the result is free.
// Reset clears the entry count, tokens and result valid; slot contents are
// not reset. A stalled result holds the next command off, and a finished
// search waits in place until the result register is free.
module fifo_ready_queue_with_removal (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] thread_id
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] dispatched_id, [12:8] queue_count, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  frq_pkg::cell_ctrl_t                               cell_ctrl;
  logic [frq_pkg::QUEUE_DEPTH-1:0]                   wr_en;
  logic [frq_pkg::ID_WIDTH-1:0]                      wr_data;
  logic [frq_pkg::ID_WIDTH-1:0]                      key;
  logic [frq_pkg::QUEUE_DEPTH-1:0][frq_pkg::ID_WIDTH-1:0] cell_id;
  logic [frq_pkg::QUEUE_DEPTH-1:0]                   cell_tok;
  logic [frq_pkg::QUEUE_DEPTH-1:0]                   cell_hit;
  logic [7:0]                                        disp;
  logic [4:0]                                        rcnt;

  // Command sequencer
  frq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_i     (s_axis_tuser),
    .tid_i     (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_o  (m_axis_tuser),
    .disp_o    (disp),
    .count_o   (rcnt),
    .ctrl_o    (cell_ctrl),
    .wr_en_o   (wr_en),
    .wr_data_o (wr_data),
    .key_o     (key),
    .head_id_i (cell_id[0]),
    .hit_i     (cell_hit)
  );

  // Slot chain, head in cell 0; each cell but the top shifts from its upper neighbor
  for (genvar g = 0; g < frq_pkg::QUEUE_DEPTH; g++) begin : g_cell
    logic [frq_pkg::ID_WIDTH-1:0] next_id;
    logic                         tok_in;

    if (g == frq_pkg::QUEUE_DEPTH - 1) begin : g_top
      assign next_id = cell_id[g];
    end else begin : g_mid
      assign next_id = cell_id[g+1];
    end

    if (g == 0) begin : g_first
      assign tok_in = cell_ctrl.start;
    end else begin : g_rest
      assign tok_in = cell_tok[g-1];
    end

    frq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .wr_en_i   (wr_en[g]),
      .wr_data_i (wr_data),
      .key_i     (key),
      .next_id_i (next_id),
      .tok_i     (tok_in),
      .id_o      (cell_id[g]),
      .tok_o     (cell_tok[g]),
      .hit_o     (cell_hit[g])
    );
  end

  assign m_axis_tdata = {3'b000, rcnt, disp};

endmodule
